FILE: rtl/lqrobs_pkg.sv
// ----------------------------------------------------------------------------
// LQR observer servo control - shared package
// Types, codes, the microprogram and the observer coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

package lqrobs_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned LimW  = 31;
    localparam int unsigned PcW   = 5;
    localparam int unsigned KIdxW = 4;
    localparam int unsigned CfgIdxW = 2;

    localparam logic signed [DataW-1:0] QMax = 32'sh7FFF_FFFF;
    localparam logic signed [DataW-1:0] QMin = 32'sh8000_0000;

    localparam logic signed [DataW-1:0] GainOneRst   = -32'sd280245;
    localparam logic signed [DataW-1:0] GainTwoRst   = -32'sd75393;
    localparam logic signed [DataW-1:0] GainThreeRst = -32'sd104176;
    localparam logic [LimW-1:0]         LimitRst     = 31'd58982;
    localparam logic signed [DataW-1:0] EstOneRst    = 32'sd1179648;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_GAIN_ONE   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_GAIN_TWO   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_GAIN_THREE = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_LIMIT      = 2'd3;

    // sequencer ops
    localparam logic [1:0] SEQ_NEXT     = 2'd0;
    localparam logic [1:0] SEQ_WAIT_IN  = 2'd1;
    localparam logic [1:0] SEQ_WAIT_OUT = 2'd2;
    localparam logic [1:0] SEQ_END      = 2'd3;

    // multiplier operand A
    localparam logic [1:0] A_G1 = 2'd0;
    localparam logic [1:0] A_G2 = 2'd1;
    localparam logic [1:0] A_G3 = 2'd2;
    localparam logic [1:0] A_K  = 2'd3;

    // multiplier operand B
    localparam logic [2:0] B_E1   = 3'd0;
    localparam logic [2:0] B_E2   = 3'd1;
    localparam logic [2:0] B_E3   = 3'd2;
    localparam logic [2:0] B_ROLL = 3'd3;
    localparam logic [2:0] B_CMD  = 3'd4;

    // sum destinations
    localparam logic [1:0] DST_FB = 2'd0;
    localparam logic [1:0] DST_N1 = 2'd1;
    localparam logic [1:0] DST_N2 = 2'd2;
    localparam logic [1:0] DST_N3 = 2'd3;

    typedef struct packed {
        logic [1:0]       seq;
        logic             mul_en;
        logic [1:0]       a_sel;
        logic [2:0]       b_sel;
        logic [KIdxW-1:0] k_idx;
        logic             first;
        logic             last;
        logic [1:0]       dst;
        logic             do_cmd;
        logic             do_commit;
    } t_uop;

    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic [1:0] dst;
    } t_mac_tag;

    typedef struct packed {
        logic                    valid;
        logic [1:0]              dst;
        logic signed [DataW-1:0] value;
    } t_mac_wr;

    function automatic logic signed [DataW-1:0] sat_add(
        input logic signed [DataW-1:0] a,
        input logic signed [DataW-1:0] b
    );
        logic signed [DataW:0] s;
        s = {a[DataW-1], a} + {b[DataW-1], b};
        if (s[DataW] != s[DataW-1]) begin
            sat_add = s[DataW] ? QMin : QMax;
        end else begin
            sat_add = s[DataW-1:0];
        end
    endfunction

    // observer matrix, Q16.16; rows n1, n3, n2 in issue order
    function automatic logic signed [DataW-1:0] lqrobs_coef(input logic [KIdxW-1:0] idx);
        case (idx)
            4'd0:    lqrobs_coef = 32'sd47396;
            4'd1:    lqrobs_coef = -32'sd7;
            4'd2:    lqrobs_coef = 32'sd315;
            4'd3:    lqrobs_coef = 32'sd18114;
            4'd4:    lqrobs_coef = -32'sd32820;
            4'd5:    lqrobs_coef = -32'sd3788;
            4'd6:    lqrobs_coef = 32'sd60313;
            4'd7:    lqrobs_coef = 32'sd23350;
            4'd8:    lqrobs_coef = 32'sd1402;
            4'd9:    lqrobs_coef = 32'sd48208;
            4'd10:   lqrobs_coef = 32'sd518;
            4'd11:   lqrobs_coef = 32'sd17708;
            default: lqrobs_coef = '0;
        endcase
    endfunction

    function automatic t_uop mul_uop(
        input logic [1:0]       a_sel,
        input logic [2:0]       b_sel,
        input logic [KIdxW-1:0] k_idx,
        input logic             first,
        input logic             last,
        input logic [1:0]       dst
    );
        t_uop u;
        u           = '0;
        u.seq       = SEQ_NEXT;
        u.mul_en    = 1'b1;
        u.a_sel     = a_sel;
        u.b_sel     = b_sel;
        u.k_idx     = k_idx;
        u.first     = first;
        u.last      = last;
        u.dst       = dst;
        mul_uop     = u;
    endfunction

    // Microprogram. Products pass through r_prod and r_term to the accumulator.
    function automatic t_uop lqrobs_rom(input logic [PcW-1:0] pc);
        t_uop u;
        u     = '0;
        u.seq = SEQ_NEXT;
        case (pc)
            5'd0:  u.seq = SEQ_WAIT_IN;
            5'd1:  u = mul_uop(A_G1, B_E1,   4'd0,  1'b1, 1'b0, DST_FB);
            5'd2:  u = mul_uop(A_G2, B_E2,   4'd0,  1'b0, 1'b0, DST_FB);
            5'd3:  u = mul_uop(A_G3, B_E3,   4'd0,  1'b0, 1'b1, DST_FB);
            5'd4:  u = mul_uop(A_K,  B_E1,   4'd0,  1'b1, 1'b0, DST_N1);
            5'd5:  u = mul_uop(A_K,  B_E2,   4'd1,  1'b0, 1'b0, DST_N1);
            5'd6:  begin
                u.seq    = SEQ_WAIT_OUT;
                u.do_cmd = 1'b1;
            end
            5'd7:  u = mul_uop(A_K,  B_E3,   4'd2,  1'b0, 1'b0, DST_N1);
            5'd8:  u = mul_uop(A_K,  B_ROLL, 4'd3,  1'b0, 1'b1, DST_N1);
            5'd9:  u = mul_uop(A_K,  B_E1,   4'd4,  1'b1, 1'b0, DST_N3);
            5'd10: u = mul_uop(A_K,  B_E2,   4'd5,  1'b0, 1'b0, DST_N3);
            5'd11: u = mul_uop(A_K,  B_E3,   4'd6,  1'b0, 1'b0, DST_N3);
            5'd12: u = mul_uop(A_K,  B_ROLL, 4'd7,  1'b0, 1'b1, DST_N3);
            5'd13: u = mul_uop(A_K,  B_E1,   4'd8,  1'b1, 1'b0, DST_N2);
            5'd14: u = mul_uop(A_K,  B_E2,   4'd9,  1'b0, 1'b0, DST_N2);
            5'd15: u = mul_uop(A_K,  B_E3,   4'd10, 1'b0, 1'b0, DST_N2);
            5'd16: u = mul_uop(A_K,  B_CMD,  4'd11, 1'b0, 1'b1, DST_N2);
            5'd17: u.seq = SEQ_NEXT;
            5'd18: u.seq = SEQ_NEXT;
            5'd19: begin
                u.seq       = SEQ_END;
                u.do_commit = 1'b1;
            end
            default: u.seq = SEQ_END;
        endcase
        lqrobs_rom = u;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lqr_observer_servo_control.sv
// ----------------------------------------------------------------------------
// LQR observer servo control - top level
// Microcoded state-feedback loop with a three-state Luenberger observer.
// ----------------------------------------------------------------------------
// The command is registered at the output-wait step; a waiting command holds
// the program there, and a new roll angle is taken only at its first step.
// The shared multiplier issues at most one of fifteen products per step; the
// program runs 20 steps including pipeline drain and the state update.
// Reset: gains, limit and estimates return to their defaults, the command
// accumulator clears and the sequencer waits at its first step.
`default_nettype none

module lqr_observer_servo_control (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [lqrobs_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  wire logic [lqrobs_pkg::DataW-1:0]          i_cfg_data,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic signed [lqrobs_pkg::DataW-1:0]   i_roll_angle,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [lqrobs_pkg::DataW-1:0]        o_servo_command,
    output logic                                       o_saturated
);
    import lqrobs_pkg::*;

    logic signed [DataW-1:0] r_gain1, r_gain2, r_gain3;
    logic [LimW-1:0]         r_limit;
    logic signed [DataW-1:0] r_est1, r_est2, r_est3;
    logic signed [DataW-1:0] r_cmd;
    logic signed [DataW-1:0] r_roll;
    logic signed [DataW-1:0] r_fb, r_new1, r_new2, r_new3;
    logic                    r_sat;
    logic                    r_out_valid;
    logic [PcW-1:0]          r_pc;

    logic [PcW-1:0]          n_pc;
    t_uop                    w_uop;
    logic                    w_out_free;
    logic                    w_cmd_fire;
    logic signed [DataW-1:0] w_op_a, w_op_b;
    t_mac_tag                w_tag;
    t_mac_wr                 w_wr;
    logic signed [DataW-1:0] w_neg_fb, w_cmd_raw, w_lim, n_cmd;
    logic                    n_sat;

    assign w_uop      = lqrobs_rom(r_pc);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cmd_fire = w_uop.do_cmd && w_out_free;

    always_comb begin
        case (w_uop.seq)
            SEQ_NEXT:     n_pc = r_pc + 1'b1;
            SEQ_WAIT_IN:  n_pc = i_in_valid ? r_pc + 1'b1 : r_pc;
            SEQ_WAIT_OUT: n_pc = w_out_free ? r_pc + 1'b1 : r_pc;
            SEQ_END:      n_pc = '0;
            default:      n_pc = '0;
        endcase
    end

    // operand select
    always_comb begin
        case (w_uop.a_sel)
            A_G1:    w_op_a = r_gain1;
            A_G2:    w_op_a = r_gain2;
            A_G3:    w_op_a = r_gain3;
            A_K:     w_op_a = lqrobs_coef(w_uop.k_idx);
            default: w_op_a = '0;
        endcase
        case (w_uop.b_sel)
            B_E1:    w_op_b = r_est1;
            B_E2:    w_op_b = r_est2;
            B_E3:    w_op_b = r_est3;
            B_ROLL:  w_op_b = r_roll;
            B_CMD:   w_op_b = r_cmd;
            default: w_op_b = '0;
        endcase
    end

    assign w_tag.valid = w_uop.mul_en;
    assign w_tag.first = w_uop.first;
    assign w_tag.last  = w_uop.last;
    assign w_tag.dst   = w_uop.dst;

    lqrobs_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (w_op_a),
        .i_b     (w_op_b),
        .i_tag   (w_tag),
        .o_wr    (w_wr)
    );

    // command update and clamp; negation of the minimum saturates
    always_comb begin
        w_neg_fb  = (r_fb == QMin) ? QMax : -r_fb;
        w_cmd_raw = sat_add(r_cmd, w_neg_fb);
        w_lim     = {1'b0, r_limit};
        if (w_cmd_raw > w_lim) begin
            n_cmd = w_lim;
            n_sat = 1'b1;
        end else if (w_cmd_raw < -w_lim) begin
            n_cmd = -w_lim;
            n_sat = 1'b1;
        end else begin
            n_cmd = w_cmd_raw;
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_out_valid <= 1'b0;
            r_gain1     <= GainOneRst;
            r_gain2     <= GainTwoRst;
            r_gain3     <= GainThreeRst;
            r_limit     <= LimitRst;
            r_est1      <= EstOneRst;
            r_est2      <= '0;
            r_est3      <= '0;
            r_cmd       <= '0;
            r_sat       <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (w_cmd_fire) begin
                r_out_valid <= 1'b1;
                r_cmd       <= n_cmd;
                r_sat       <= n_sat;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GAIN_ONE:   r_gain1 <= i_cfg_data;
                    REG_GAIN_TWO:   r_gain2 <= i_cfg_data;
                    REG_GAIN_THREE: r_gain3 <= i_cfg_data;
                    REG_LIMIT:      r_limit <= i_cfg_data[LimW-1:0];
                    default:        r_limit <= r_limit;
                endcase
            end
            if (w_uop.do_commit) begin
                r_est1 <= r_new1;
                r_est2 <= r_new2;
                r_est3 <= r_new3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uop.seq == SEQ_WAIT_IN && i_in_valid) begin
            r_roll <= i_roll_angle;
        end
        if (w_wr.valid) begin
            case (w_wr.dst)
                DST_FB:  r_fb   <= w_wr.value;
                DST_N1:  r_new1 <= w_wr.value;
                DST_N2:  r_new2 <= w_wr.value;
                DST_N3:  r_new3 <= w_wr.value;
                default: r_fb   <= w_wr.value;
            endcase
        end
    end

    assign o_in_stall      = (w_uop.seq != SEQ_WAIT_IN);
    assign o_out_valid     = r_out_valid;
    assign o_servo_command = r_cmd;
    assign o_saturated     = r_sat;

endmodule

`default_nettype wire

FILE: rtl/lqrobs_mac.sv
// ----------------------------------------------------------------------------
// LQR observer servo control - multiply-accumulate pipeline
// Registered 32x32 product, Q16.16 round half up with saturation, then a
// saturating accumulator that posts each finished sum with its destination.
// ----------------------------------------------------------------------------
`default_nettype none

module lqrobs_mac (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic signed [lqrobs_pkg::DataW-1:0] i_a,
    input  wire logic signed [lqrobs_pkg::DataW-1:0] i_b,
    input  wire lqrobs_pkg::t_mac_tag                i_tag,
    output lqrobs_pkg::t_mac_wr                      o_wr
);
    import lqrobs_pkg::*;

    logic signed [2*DataW-1:0] r_prod;
    t_mac_tag                  r_tag1;
    logic signed [DataW-1:0]   r_term;
    t_mac_tag                  r_tag2;
    logic signed [DataW-1:0]   r_acc;

    logic signed [2*DataW-1:0] w_prod;
    logic signed [2*DataW-1:0] w_shr;
    logic signed [DataW-1:0]   n_term;
    logic signed [DataW-1:0]   n_acc;

    assign w_prod = i_a * i_b;

    // floor((p + 2^15) / 2^16), then clip to 32 bits
    always_comb begin
        w_shr = (r_prod + 64'sd32768) >>> 16;
        if (w_shr > 64'sd2147483647) begin
            n_term = QMax;
        end else if (w_shr < -64'sd2147483648) begin
            n_term = QMin;
        end else begin
            n_term = w_shr[DataW-1:0];
        end
    end

    assign n_acc = r_tag2.first ? r_term : sat_add(r_acc, r_term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_term <= n_term;
        if (r_tag2.valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_wr.valid = r_tag2.valid && r_tag2.last;
    assign o_wr.dst   = r_tag2.dst;
    assign o_wr.value = n_acc;

endmodule

`default_nettype wire

FILE: dv/lqr_observer_servo_control_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LQR observer servo control - result checker
// Tracks register writes, predicts the clamped command and saturation flag for
// every accepted roll angle, and compares each accepted command in order.
// ----------------------------------------------------------------------------

module lqr_observer_servo_control_checker (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [lqrobs_pkg::CfgIdxW-1:0]            i_cfg_index,
    input  logic [lqrobs_pkg::DataW-1:0]              i_cfg_data,
    input  logic                                      i_in_valid,
    input  logic                                      i_in_stall,
    input  logic signed [lqrobs_pkg::DataW-1:0]       i_roll_angle,
    input  logic                                      i_out_valid,
    input  logic                                      i_out_stall,
    input  logic signed [lqrobs_pkg::DataW-1:0]       i_servo_command,
    input  logic                                      i_saturated,
    output int                                        o_fail_count,
    output int                                        o_pending
);
    import lqrobs_pkg::*;

    typedef logic signed [DataW-1:0] t_q16;

    typedef struct packed {
        t_q16 command;
        logic sat;
    } t_servo_result;

    // observer matrix in Q16.16
    localparam t_q16 K_N1_E1   = 32'sd47396;
    localparam t_q16 K_N1_E2   = -32'sd7;
    localparam t_q16 K_N1_E3   = 32'sd315;
    localparam t_q16 K_N1_ROLL = 32'sd18114;
    localparam t_q16 K_N2_E1   = 32'sd1402;
    localparam t_q16 K_N2_E2   = 32'sd48208;
    localparam t_q16 K_N2_E3   = 32'sd518;
    localparam t_q16 K_N2_CMD  = 32'sd17708;
    localparam t_q16 K_N3_E1   = -32'sd32820;
    localparam t_q16 K_N3_E2   = -32'sd3788;
    localparam t_q16 K_N3_E3   = 32'sd60313;
    localparam t_q16 K_N3_ROLL = 32'sd23350;

    t_q16 gain_one_q, gain_two_q, gain_three_q, limit_q;
    t_q16 est_one, est_two, est_three, cmd_acc;
    t_servo_result expected_cmds[$];
    int fail_total;

    function automatic t_q16 q_clip(input longint v);
        if (v > longint'(QMax)) return QMax;
        if (v < longint'(QMin)) return QMin;
        return t_q16'(v);
    endfunction

    // round half up, then saturate
    function automatic t_q16 q_mul(input t_q16 a, input t_q16 b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return q_clip(p >>> 16);
    endfunction

    function automatic t_q16 q_add(input t_q16 a, input t_q16 b);
        return q_clip(longint'(a) + longint'(b));
    endfunction

    function automatic t_q16 q_neg(input t_q16 a);
        return q_clip(-longint'(a));
    endfunction

    task automatic predict_command(input t_q16 roll);
        t_q16 fb, cmd, n1, n2, n3;
        logic sat;
        fb  = q_add(q_add(q_mul(gain_one_q, est_one), q_mul(gain_two_q, est_two)),
                    q_mul(gain_three_q, est_three));
        cmd = q_add(cmd_acc, q_neg(fb));
        sat = 1'b0;
        if (cmd > limit_q) begin
            cmd = limit_q;
            sat = 1'b1;
        end else if (cmd < -limit_q) begin
            cmd = -limit_q;
            sat = 1'b1;
        end
        cmd_acc = cmd;
        expected_cmds.push_back('{command: cmd, sat: sat});

        n1 = q_add(q_add(q_add(q_mul(K_N1_E1, est_one), q_mul(K_N1_E2, est_two)),
                         q_mul(K_N1_E3, est_three)), q_mul(K_N1_ROLL, roll));
        n2 = q_add(q_add(q_add(q_mul(K_N2_E1, est_one), q_mul(K_N2_E2, est_two)),
                         q_mul(K_N2_E3, est_three)), q_mul(K_N2_CMD, cmd));
        n3 = q_add(q_add(q_add(q_mul(K_N3_E1, est_one), q_mul(K_N3_E2, est_two)),
                         q_mul(K_N3_E3, est_three)), q_mul(K_N3_ROLL, roll));
        est_one   = n1;
        est_two   = n2;
        est_three = n3;
    endtask

    task automatic check_command();
        t_servo_result want;
        if (expected_cmds.size() == 0) begin
            $display("%0t: unexpected command, expected none actual %0d sat %0b",
                     $time, i_servo_command, i_saturated);
            fail_total++;
        end else begin
            want = expected_cmds.pop_front();
            if (i_servo_command !== want.command) begin
                $display("%0t: servo_command mismatch, expected %0d actual %0d",
                         $time, want.command, i_servo_command);
                fail_total++;
            end
            if (i_saturated !== want.sat) begin
                $display("%0t: saturated mismatch, expected %0b actual %0b",
                         $time, want.sat, i_saturated);
                fail_total++;
            end
        end
    endtask

    initial begin
        fail_total   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gain_one_q   = GainOneRst;
            gain_two_q   = GainTwoRst;
            gain_three_q = GainThreeRst;
            limit_q      = {1'b0, LimitRst};
            est_one      = EstOneRst;
            est_two      = '0;
            est_three    = '0;
            cmd_acc      = '0;
            expected_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GAIN_ONE:   gain_one_q   = i_cfg_data;
                    REG_GAIN_TWO:   gain_two_q   = i_cfg_data;
                    REG_GAIN_THREE: gain_three_q = i_cfg_data;
                    REG_LIMIT:      limit_q      = {1'b0, i_cfg_data[LimW-1:0]};
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_command(i_roll_angle);
            if (i_out_valid && !i_out_stall) check_command();
        end
        o_pending    <= expected_cmds.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: dv/lqr_observer_servo_control_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LQR observer servo control - testbench top
// Drives roll angles and register writes with random gaps and output stalls;
// a checker beside the block predicts and compares every servo command.
// ----------------------------------------------------------------------------

module lqr_observer_servo_control_tb;
    import lqrobs_pkg::*;

    typedef logic signed [DataW-1:0] t_q16;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int HOLD_CYCLES   = 300;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [DataW-1:0]    i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    t_q16                i_roll_angle;
    logic                o_out_valid;
    logic                i_out_stall;
    t_q16                o_servo_command;
    logic                o_saturated;

    int fail_count;
    int pending_cmds;
    int cycle_count;
    bit quiet;
    int hold_len;

    lqr_observer_servo_control uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_roll_angle    (i_roll_angle),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_servo_command (o_servo_command),
        .o_saturated     (o_saturated)
    );

    lqr_observer_servo_control_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_roll_angle    (i_roll_angle),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_servo_command (o_servo_command),
        .i_saturated     (o_saturated),
        .o_fail_count    (fail_count),
        .o_pending       (pending_cmds)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial cycle_count = 0;
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // output side: random stalls, plus one long hold on request
    initial begin
        int wait_n;
        i_out_stall = 1'b0;
        forever begin
            if (hold_len != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end
            wait_n = quiet ? 0 : $urandom_range(0, 6);
            if (wait_n != 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    task automatic send_roll(input t_q16 roll);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_roll_angle <= roll;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // stop offering, wait for every command, then let the observer update finish
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cmds != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input t_q16 g1, input t_q16 g2, input t_q16 g3,
                                 input logic [DataW-1:0] lim);
        put_reg(REG_GAIN_ONE, g1);
        put_reg(REG_GAIN_TWO, g2);
        put_reg(REG_GAIN_THREE, g3);
        put_reg(REG_LIMIT, lim);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_q16 pick_roll();
        case ($urandom_range(0, 9))
            0:       return QMax;
            1:       return QMin;
            2, 3, 4, 5, 6: return t_q16'($urandom_range(0, 262143)) - 32'sd131072;
            default: return t_q16'($urandom);
        endcase
    endfunction

    function automatic t_q16 pick_gain(input t_q16 nominal);
        case ($urandom_range(0, 9))
            0, 1:    return nominal;
            2:       return QMax;
            3:       return QMin;
            4, 5, 6: return t_q16'($urandom_range(0, 1048575)) - 32'sd524288;
            default: return t_q16'($urandom);
        endcase
    endfunction

    // bit 31 is outside the limit register and must be dropped
    function automatic logic [DataW-1:0] pick_limit();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2, 3, 4, 5, 6:
                return {1'($urandom_range(0, 1)), 31'($urandom_range(0, 262143))};
            default: return $urandom;
        endcase
    endfunction

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = REG_GAIN_ONE;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_roll_angle = '0;
        quiet        = 1'b0;
        hold_len     = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset gains: the initial estimate drives the command into the clamp
        send_roll('0);
        send_roll(32'sd6554);
        send_roll(-32'sd6554);
        send_roll(QMax);
        send_roll(QMin);

        // extreme gains with the widest limit: the accumulator sum saturates
        wait_idle();
        load_settings(QMax, QMin, QMax, 32'hFFFF_FFFF);
        send_roll(QMax);
        send_roll(QMin);
        send_roll('0);
        send_roll(-32'sd1);

        wait_idle();
        load_settings(QMin, QMin, QMin, 32'h7FFF_FFFF);
        send_roll(32'sd1);
        send_roll(QMin);
        send_roll(QMax);

        // narrow limit clamps, then zero gains hold the command on the boundary
        wait_idle();
        load_settings(QMin, QMin, QMin, 32'sd65536);
        send_roll(32'sd65536);
        send_roll(-32'sd65536);
        wait_idle();
        load_settings('0, '0, '0, 32'sd65536);
        send_roll(32'sd100);
        send_roll(-32'sd100);

        // zero limit: nonzero command forced to zero and flagged, then stays at zero
        wait_idle();
        load_settings('0, '0, '0, '0);
        send_roll(32'sd3000);
        send_roll(-32'sd3000);
        wait_idle();
        load_settings(GainOneRst, GainTwoRst, GainThreeRst, {1'b0, LimitRst});
        send_roll(32'sd13107);
        send_roll(-32'sd13107);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            load_settings(pick_gain(GainOneRst), pick_gain(GainTwoRst),
                          pick_gain(GainThreeRst), pick_limit());
            quiet = (phase % 3 == 0);
            if (phase == 2) hold_len = HOLD_CYCLES;
            for (int n = 0; n < PHASE_ITEMS; n++) send_roll(pick_roll());
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lqrobs_pkg.sv
rtl/lqrobs_mac.sv
rtl/lqr_observer_servo_control.sv
dv/lqr_observer_servo_control_checker.sv
dv/lqr_observer_servo_control_tb.sv
